@@ rtl/core/wwoc_pkg.sv @@
// Shared types and constants for the whole-word occurrence counter.
// Used by the top level, wwoc_front and wwoc_back; depends on nothing.
package wwoc_pkg;

  localparam int MAX_REPORTS = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_W       = 4;

  typedef enum logic [1:0] {
    OP_LOAD_CHAR  = 2'd0,
    OP_SET_LENGTH = 2'd1,
    OP_TEXT_BYTE  = 2'd2,
    OP_END_TEXT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD_CHAR,
    CMD_SET_LENGTH,
    CMD_LETTER,
    CMD_WORD_END,
    CMD_END_TEXT
  } cmd_kind_t;

  typedef enum logic {
    BK_RUN,
    BK_REPORT
  } back_state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] pattern_slot;
    logic [4:0] char_position;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]  report_slot;
    logic [31:0] match_count;
    logic        last;
  } result_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] slot;
    logic [4:0] pos;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ rtl/core/whole_word_occurrence_counter.sv @@
// Top level of the whole-word occurrence counter: front, two queues, back.
// Depends on wwoc_pkg, wwoc_front, wwoc_fifo and wwoc_back.
//
// Counts case-sensitive whole-word hits of up to NUM_PATTERNS stored
// patterns, capped at MAX_REPORTS (words are runs of ASCII letters), and
// reports them on end of text. The back end takes one load-char, set-length
// or text-byte item per clock while in its run state, so text streams at
// one byte per clock with every pattern compared in parallel against a
// prefetched character per pattern memory. An end-of-text item closes the
// open word and moves the back end to its report state, which makes one
// report transfer per cycle while the result queue is not full, for each of
// the n clamped active patterns, through the single-write result queue.
// Write active_patterns only while no item is in flight and no result waits.
module whole_word_occurrence_counter #(
  parameter int NUM_PATTERNS = 8,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  wwoc_pkg::item_t            item,
  output logic                       full,
  input  logic                       pop,
  output wwoc_pkg::result_t          result,
  output logic                       empty,
  input  logic                       cfg_write,
  input  logic [wwoc_pkg::CFG_W-1:0] cfg_data
);

  wwoc_pkg::cmd_t    q_cmd;
  wwoc_pkg::cmd_t    cmd;
  wwoc_pkg::result_t res;
  logic [$bits(wwoc_pkg::cmd_t)-1:0]    cmd_bits;
  logic [$bits(wwoc_pkg::result_t)-1:0] result_bits;
  logic q_push;
  logic q_full;
  logic q_empty;
  logic cmd_pop;
  logic res_push;
  logic res_full;

  wwoc_front #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .push  (push),
    .item  (item),
    .full  (full),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd (q_cmd)
  );

  wwoc_fifo #(
    .WIDTH($bits(wwoc_pkg::cmd_t)),
    .DEPTH(wwoc_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_cmd),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(cmd_bits),
    .empty(q_empty)
  );

  assign cmd = wwoc_pkg::cmd_t'(cmd_bits);

  wwoc_back #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .cmd_valid(!q_empty),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  wwoc_fifo #(
    .WIDTH($bits(wwoc_pkg::result_t)),
    .DEPTH(wwoc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(result_bits),
    .empty(empty)
  );

  assign result = wwoc_pkg::result_t'(result_bits);

endmodule

@@ rtl/core/wwoc_fifo.sv @@
// Small register queue with count-based full and empty flags.
// Generic width; no package dependency.
module wwoc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

@@ rtl/core/wwoc_front.sv @@
// Front end: accepts input items, classifies them and drops ignored ones.
// Depends on wwoc_pkg; feeds the command queue in front of wwoc_back.
module wwoc_front #(
  parameter int NUM_PATTERNS = 8,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic            push,
  input  wwoc_pkg::item_t item,
  output logic            full,
  input  logic            q_full,
  output logic            q_push,
  output wwoc_pkg::cmd_t  q_cmd
);

  logic letter;
  logic slot_ok;
  logic pos_ok;
  logic len_ok;

  assign letter  = (item.value >= 8'h41 && item.value <= 8'h5A) ||
                   (item.value >= 8'h61 && item.value <= 8'h7A);
  assign slot_ok = 32'(item.pattern_slot) < NUM_PATTERNS;
  assign pos_ok  = 32'(item.char_position) < MAX_WORD_LEN;
  assign len_ok  = 32'(item.value) <= MAX_WORD_LEN;

  always_comb begin
    q_cmd.slot = item.pattern_slot;
    q_cmd.pos  = item.char_position;
    q_cmd.data = item.value;
    case (item.op)
      wwoc_pkg::OP_LOAD_CHAR: begin
        q_cmd.kind = (slot_ok && pos_ok) ? wwoc_pkg::CMD_LOAD_CHAR : wwoc_pkg::CMD_NONE;
      end
      wwoc_pkg::OP_SET_LENGTH: begin
        q_cmd.kind = slot_ok ? wwoc_pkg::CMD_SET_LENGTH : wwoc_pkg::CMD_NONE;
        // oversize length stores zero, which never matches
        q_cmd.data = len_ok ? item.value : 8'd0;
      end
      wwoc_pkg::OP_TEXT_BYTE: begin
        q_cmd.kind = letter ? wwoc_pkg::CMD_LETTER : wwoc_pkg::CMD_WORD_END;
      end
      wwoc_pkg::OP_END_TEXT: begin
        q_cmd.kind = wwoc_pkg::CMD_END_TEXT;
      end
      default: begin
        q_cmd.kind = wwoc_pkg::CMD_NONE;
      end
    endcase
  end

  // Drop ignored items here so they never occupy a queue slot.
  assign full   = q_full;
  assign q_push = push && !q_full && (q_cmd.kind != wwoc_pkg::CMD_NONE);

endmodule

@@ rtl/core/wwoc_back.sv @@
// Back end: pattern memories, word tracking, match counters and reporting.
// Depends on wwoc_pkg; pops the command queue and pushes the result queue.
module wwoc_back #(
  parameter int NUM_PATTERNS = 8,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [wwoc_pkg::CFG_W-1:0] cfg_data,
  input  wwoc_pkg::cmd_t             cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  output wwoc_pkg::result_t          res,
  output logic                       res_push,
  input  logic                       res_full
);

  localparam int LW    = $clog2(MAX_WORD_LEN + 1);
  localparam int AW    = $clog2(MAX_WORD_LEN);
  localparam int LIMIT = (NUM_PATTERNS < wwoc_pkg::MAX_REPORTS) ?
                         NUM_PATTERNS : wwoc_pkg::MAX_REPORTS;

  wwoc_pkg::back_state_t state, state_next;

  logic [wwoc_pkg::CFG_W-1:0] active_patterns;
  logic [2:0]                 idx, idx_next;
  logic [LW-1:0]              word_length, word_length_next;
  logic                       inside_word, inside_word_next;
  logic [NUM_PATTERNS-1:0]    still_matching, still_matching_next;
  logic [LW-1:0]              lengths [NUM_PATTERNS];
  logic [31:0]                counts [NUM_PATTERNS];
  logic [7:0]                 rd_char [NUM_PATTERNS];

  logic [NUM_PATTERNS-1:0] hits;
  logic [NUM_PATTERNS-1:0] count_inc;
  logic                    count_clr;
  logic                    load_we;
  logic                    len_we;
  logic                    at_max;
  logic [wwoc_pkg::CFG_W-1:0] act_n;
  logic [2:0]              last_idx;
  logic [31:0]             sel_count;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;

  // Number of reported patterns: zero acts as one, clamp to NUM_PATTERNS and MAX_REPORTS.
  always_comb begin
    act_n = (active_patterns == '0) ? wwoc_pkg::CFG_W'(1) : active_patterns;
    if (32'(act_n) > LIMIT) begin
      act_n = wwoc_pkg::CFG_W'(LIMIT);
    end
    last_idx = 3'(act_n - 1'b1);
  end

  assign at_max = 32'(word_length) >= MAX_WORD_LEN;

  always_comb begin
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      hits[k] = inside_word && still_matching[k] && (lengths[k] != '0) &&
                (lengths[k] == word_length) && (counts[k] != '1) &&
                (32'(act_n) > k);
    end
  end

  always_comb begin
    sel_count = '0;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      if (32'(idx) == k) begin
        sel_count = counts[k];
      end
    end
  end

  always_comb begin
    state_next          = state;
    idx_next            = idx;
    word_length_next    = word_length;
    inside_word_next    = inside_word;
    still_matching_next = still_matching;
    count_inc           = '0;
    count_clr           = 1'b0;
    load_we             = 1'b0;
    len_we              = 1'b0;
    cmd_pop             = 1'b0;
    res_push            = 1'b0;
    res.report_slot     = idx;
    res.match_count     = sel_count;
    res.last            = (idx == last_idx);
    case (state)
      wwoc_pkg::BK_RUN: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            wwoc_pkg::CMD_LOAD_CHAR: begin
              load_we = 1'b1;
            end
            wwoc_pkg::CMD_SET_LENGTH: begin
              len_we = 1'b1;
            end
            wwoc_pkg::CMD_LETTER: begin
              inside_word_next = 1'b1;
              if (at_max) begin
                still_matching_next = '0;
              end else begin
                word_length_next = word_length + 1'b1;
                for (int k = 0; k < NUM_PATTERNS; k++) begin
                  if (word_length >= lengths[k] || rd_char[k] != cmd.data) begin
                    still_matching_next[k] = 1'b0;
                  end
                end
              end
            end
            wwoc_pkg::CMD_WORD_END: begin
              count_inc           = hits;
              word_length_next    = '0;
              inside_word_next    = 1'b0;
              still_matching_next = '1;
            end
            wwoc_pkg::CMD_END_TEXT: begin
              count_inc           = hits;
              word_length_next    = '0;
              inside_word_next    = 1'b0;
              still_matching_next = '1;
              idx_next            = '0;
              state_next          = wwoc_pkg::BK_REPORT;
            end
            default: begin
            end
          endcase
        end
      end
      wwoc_pkg::BK_REPORT: begin
        // One report per cycle while the result queue is not full; clear all counts with the final transfer.
        if (!res_full) begin
          res_push = 1'b1;
          if (idx == last_idx) begin
            count_clr  = 1'b1;
            state_next = wwoc_pkg::BK_RUN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = wwoc_pkg::BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= wwoc_pkg::BK_RUN;
      idx             <= '0;
      active_patterns <= wwoc_pkg::CFG_W'(1);
      word_length     <= '0;
      inside_word     <= 1'b0;
      still_matching  <= '1;
    end else begin
      state          <= state_next;
      idx            <= idx_next;
      word_length    <= word_length_next;
      inside_word    <= inside_word_next;
      still_matching <= still_matching_next;
      if (cfg_write) begin
        active_patterns <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      if (rst) begin
        lengths[k] <= '0;
        counts[k]  <= '0;
      end else begin
        if (len_we && 32'(cmd.slot) == k) begin
          lengths[k] <= LW'(cmd.data);
        end
        if (count_clr) begin
          counts[k] <= '0;
        end else if (count_inc[k]) begin
          counts[k] <= counts[k] + 1'b1;
        end
      end
    end
  end

  // Prefetch the character at the next word position so the compare
  // for the following letter sees it registered; forward a same-cycle load.
  assign wr_addr = AW'(cmd.pos);
  assign rd_addr = (32'(word_length_next) < MAX_WORD_LEN) ? AW'(word_length_next) : '0;

  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_pat
    logic [7:0] chars [MAX_WORD_LEN];
    logic [7:0] q;
    logic       we;

    assign we = load_we && (32'(cmd.slot) == g);

    always_ff @(posedge clk) begin
      if (we) begin
        chars[wr_addr] <= cmd.data;
      end
    end

    always_ff @(posedge clk) begin
      q <= (we && wr_addr == rd_addr) ? cmd.data : chars[rd_addr];
    end

    assign rd_char[g] = q;
  end

endmodule

@@ sim/tb_whole_word_occurrence_counter.sv @@
// Self-checking testbench for whole_word_occurrence_counter: pattern loads, text streams
// and end-of-text reports under random push/pop idling, with an in-bench count predictor.
// Depends on wwoc_pkg and the RTL under rtl/core only.
module tb_whole_word_occurrence_counter;

  localparam int NSLOT        = 8;
  localparam int WORD_MAX     = 32;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       push      = 1'b0;
  logic                       pop       = 1'b0;
  logic                       cfg_write = 1'b0;
  logic [wwoc_pkg::CFG_W-1:0] cfg_data  = '0;
  wwoc_pkg::item_t            item_in   = '0;
  wwoc_pkg::result_t          result_out;
  logic                       full;
  logic                       empty;

  whole_word_occurrence_counter u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item_in),
    .full      (full),
    .pop       (pop),
    .result    (result_out),
    .empty     (empty),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // Predicts per-pattern counts and holds the reports still owed by the block.
  class wwoc_count_scoreboard;
    logic [7:0]                 pat_char [NSLOT][WORD_MAX];
    logic [5:0]                 pat_len [NSLOT];
    logic [31:0]                hits [NSLOT];
    int unsigned                word_len;
    bit                         in_word;
    logic [NSLOT-1:0]           alive;
    logic [wwoc_pkg::CFG_W-1:0] active_cfg;
    wwoc_pkg::result_t          pending_reports[$];
    int unsigned                failures;
    int unsigned                reports_checked;

    function new();
      foreach (pat_char[s, p]) pat_char[s][p] = '0;
      foreach (pat_len[s]) begin
        pat_len[s] = '0;
        hits[s]    = '0;
      end
      active_cfg      = wwoc_pkg::CFG_W'(1);
      failures        = 0;
      reports_checked = 0;
      clear_word();
    endfunction

    function void clear_word();
      word_len = 0;
      in_word  = 1'b0;
      alive    = '1;
    endfunction

    function void set_active(logic [wwoc_pkg::CFG_W-1:0] v);
      active_cfg = v;
    endfunction

    // Zero acts as one; clamp to the slot count and the report limit.
    function int unsigned report_span();
      int unsigned n;
      n = active_cfg;
      if (n == 0) n = 1;
      if (n > NSLOT) n = NSLOT;
      if (n > wwoc_pkg::MAX_REPORTS) n = wwoc_pkg::MAX_REPORTS;
      return n;
    endfunction

    function void close_word();
      int unsigned n;
      n = report_span();
      if (in_word) begin
        for (int k = 0; k < n; k++) begin
          if (alive[k] && pat_len[k] != 0 && pat_len[k] == word_len && hits[k] != '1)
            hits[k] = hits[k] + 1;
        end
      end
      clear_word();
    endfunction

    function void take_letter(logic [7:0] b);
      in_word = 1'b1;
      // Drop every pattern once the word outgrows the longest possible one.
      if (word_len >= WORD_MAX) begin
        alive = '0;
        return;
      end
      for (int k = 0; k < NSLOT; k++) begin
        if (word_len >= pat_len[k] || pat_char[k][word_len] != b) alive[k] = 1'b0;
      end
      word_len++;
    endfunction

    function void take_item(wwoc_pkg::item_t it);
      int unsigned       n;
      wwoc_pkg::result_t rep;
      case (it.op)
        wwoc_pkg::OP_LOAD_CHAR: begin
          pat_char[it.pattern_slot][it.char_position] = it.value;
        end
        wwoc_pkg::OP_SET_LENGTH: begin
          pat_len[it.pattern_slot] = (it.value > WORD_MAX) ? 6'd0 : it.value[5:0];
        end
        wwoc_pkg::OP_TEXT_BYTE: begin
          if (is_alpha(it.value)) take_letter(it.value);
          else close_word();
        end
        wwoc_pkg::OP_END_TEXT: begin
          close_word();
          n = report_span();
          for (int k = 0; k < n; k++) begin
            rep.report_slot = 3'(k);
            rep.match_count = hits[k];
            rep.last        = (k == n - 1);
            pending_reports.push_back(rep);
          end
          foreach (hits[s]) hits[s] = '0;
          clear_word();
        end
        default: begin
        end
      endcase
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_report(wwoc_pkg::result_t got);
      wwoc_pkg::result_t want;
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("unexpected report: slot %0d count %0d last %0b",
                               got.report_slot, got.match_count, got.last));
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (got.report_slot !== want.report_slot || got.match_count !== want.match_count ||
          got.last !== want.last)
        note_failure($sformatf(
          "report mismatch: expected slot %0d count %0d last %0b, got slot %0d count %0d last %0b",
          want.report_slot, want.match_count, want.last,
          got.report_slot, got.match_count, got.last));
    endfunction
  endclass

  wwoc_count_scoreboard sb;

  logic [WORD_MAX-1:0] loaded [NSLOT] = '{default: '0};
  int unsigned         items_sent  = 0;
  int unsigned         end_texts   = 0;
  int unsigned         full_waits  = 0;
  int unsigned         cycles      = 0;
  int                  push_calm   = 0;
  int                  pop_calm    = 0;
  bit                  hold_req    = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d reports outstanding", sb.pending_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  // Stay within the loaded prefix or pick an oversize length (stored as zero), so no unwritten char is ever compared.
  function automatic int safe_length(int s);
    int p;
    p = 0;
    while (p < WORD_MAX && loaded[s][p]) p++;
    if ($urandom_range(0, 2) == 0) return $urandom_range(WORD_MAX + 1, 255);
    return $urandom_range(0, p);
  endfunction

  function automatic int any_pattern_slot();
    int cands[$];
    for (int s = 0; s < NSLOT; s++) if (sb.pat_len[s] != 0) cands.push_back(s);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  task automatic send(input wwoc_pkg::item_t it);
    int gap;
    gap = pick_gap(push_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    item_in <= it;
    @(posedge clk);
    while (full) begin
      full_waits++;
      @(posedge clk);
    end
    sb.take_item(it);
    items_sent++;
  endtask

  task automatic send_op(input wwoc_pkg::op_t code, input logic [2:0] slot,
                         input logic [4:0] pos, input logic [7:0] val);
    wwoc_pkg::item_t it;
    it.op            = code;
    it.pattern_slot  = slot;
    it.char_position = pos;
    it.value         = val;
    if (code == wwoc_pkg::OP_LOAD_CHAR) loaded[slot][pos] = 1'b1;
    if (code == wwoc_pkg::OP_END_TEXT) end_texts++;
    send(it);
  endtask

  task automatic load_pattern(input int slot, input int len);
    logic [7:0] c;
    for (int k = 0; k < len; k++) begin
      c = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : random_letter();
      send_op(wwoc_pkg::OP_LOAD_CHAR, 3'(slot), 5'(k), c);
    end
    send_op(wwoc_pkg::OP_SET_LENGTH, 3'(slot), 5'($urandom), 8'(len));
  endtask

  // Rewrite a char or a length, possibly in the middle of a word.
  task automatic meddle();
    int s;
    s = $urandom_range(0, NSLOT - 1);
    if ($urandom_range(0, 1) == 0)
      send_op(wwoc_pkg::OP_LOAD_CHAR, 3'(s), 5'($urandom), 8'($urandom));
    else
      send_op(wwoc_pkg::OP_SET_LENGTH, 3'(s), 5'($urandom), 8'(safe_length(s)));
  endtask

  task automatic end_text();
    send_op(wwoc_pkg::OP_END_TEXT, 3'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic send_separator();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'h40;
      2: b = 8'h5B;
      3: b = 8'h60;
      4: b = 8'h7B;
      5: b = 8'hFF;
      6: b = 8'h20;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (is_alpha(b));
      end
    endcase
    send_op(wwoc_pkg::OP_TEXT_BYTE, 3'($urandom), 5'($urandom), b);
  endtask

  // Stored pattern, its near misses, or a random word; now and then a long one.
  task automatic send_word();
    logic [7:0] chars[$];
    int         k;
    int         len;
    int         r;
    int         pick;
    r    = $urandom_range(0, 99);
    pick = any_pattern_slot();
    if (pick >= 0 && r < 72) begin
      len = sb.pat_len[pick];
      for (k = 0; k < len; k++) chars.push_back(sb.pat_char[pick][k]);
      if (r >= 45 && r < 55 && len > 1) begin
        void'(chars.pop_back());
      end else if (r >= 55 && r < 65) begin
        chars.push_back(random_letter());
      end else if (r >= 65) begin
        k = $urandom_range(0, len - 1);
        if (is_alpha(chars[k])) chars[k] = chars[k] ^ 8'h20;
      end
    end else begin
      len = (r >= 96) ? $urandom_range(WORD_MAX + 1, WORD_MAX + 4) : $urandom_range(1, 6);
      repeat (len) chars.push_back(random_letter());
    end
    foreach (chars[i]) begin
      if ($urandom_range(0, 24) == 0) meddle();
      send_op(wwoc_pkg::OP_TEXT_BYTE, 3'($urandom), 5'($urandom), chars[i]);
    end
  endtask

  task automatic text_chunk();
    repeat ($urandom_range(1, 4)) begin
      send_word();
      if ($urandom_range(0, 9) != 0) send_separator();
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [wwoc_pkg::CFG_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_active(v);
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned start;
    int          r;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 15)
        load_pattern($urandom_range(0, NSLOT - 1),
                     ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6));
      else if (r < 22) meddle();
      else if (r < 85) text_chunk();
      else end_text();
    end
    end_text();
  endtask

  initial begin : result_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_CYCLES;
      end else begin
        gap = pick_gap(pop_calm);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_report(result_out);
    end
  end

  initial begin : stimulus
    logic [7:0] opening_text [14] = '{8'h41, 8'h7A, 8'h20, 8'h41, 8'h7A, 8'hFF, 8'h5A,
                                      8'h40, 8'h41, 8'h7A, 8'h7A, 8'h60, 8'h5A, 8'h7B};
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: letter boundaries, non-letters, oversize length, last char slot.
    configure(wwoc_pkg::CFG_W'(8));
    send_op(wwoc_pkg::OP_LOAD_CHAR, 3'd0, 5'd0, 8'h41);
    send_op(wwoc_pkg::OP_LOAD_CHAR, 3'd0, 5'd1, 8'h7A);
    send_op(wwoc_pkg::OP_SET_LENGTH, 3'd0, 5'd0, 8'd2);
    send_op(wwoc_pkg::OP_LOAD_CHAR, 3'd7, 5'd0, 8'h5A);
    send_op(wwoc_pkg::OP_SET_LENGTH, 3'd7, 5'd31, 8'd1);
    send_op(wwoc_pkg::OP_SET_LENGTH, 3'd3, 5'd0, 8'd200);
    send_op(wwoc_pkg::OP_LOAD_CHAR, 3'd5, 5'd31, 8'hFF);
    foreach (opening_text[i]) send_op(wwoc_pkg::OP_TEXT_BYTE, 3'd0, 5'd0, opening_text[i]);
    end_text();
    // Word still open at end of text.
    send_op(wwoc_pkg::OP_TEXT_BYTE, 3'd7, 5'd31, 8'h41);
    send_op(wwoc_pkg::OP_TEXT_BYTE, 3'd7, 5'd31, 8'h7A);
    end_text();

    configure(wwoc_pkg::CFG_W'(15));
    load_pattern(6, WORD_MAX);
    random_phase(60);

    // Stall the result side while end-of-text items keep coming.
    drain();
    hold_req = 1'b1;
    repeat (4) begin
      text_chunk();
      end_text();
    end

    configure(wwoc_pkg::CFG_W'(0));
    random_phase(60);
    configure(wwoc_pkg::CFG_W'(1));
    random_phase(55);
    configure(wwoc_pkg::CFG_W'(5));
    random_phase(55);
    configure(wwoc_pkg::CFG_W'($urandom_range(2, 14)));
    random_phase(55);
    drain();

    $display("Covered %0d items including %0d end-of-text, %0d reports checked,",
             items_sent, end_texts, sb.reports_checked);
    $display("with %0d cycles of input held off by full and %0d failures",
             full_waits, sb.failures);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
